// File: sv/cpl_pkg.sv
// shared constants, codes and controller/datapath interface types for the playlist table
`default_nettype none
package cpl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int ID_W     = 16;
    localparam int DUR_W    = 16;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_DEDUP  = 3'd2;
    localparam logic [OP_W-1:0] OP_START  = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd5;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CURRENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PLAY_RD,
        S_PLAY_OUT,
        S_DEL_RD,
        S_DEL_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DD_RD,
        S_DD_HOLD,
        S_DD_JRD,
        S_DD_JCMP,
        S_DD_DEC,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_I,
        RD_I1,
        RD_J,
        RD_CUR
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_APPEND,
        WR_SHIFT,
        WR_KEEP
    } wr_sel_t;

    typedef struct packed {
        logic                load;
        logic                rd_en;
        rd_sel_t             rd_sel;
        wr_sel_t             wr_sel;
        logic                i_clr;
        logic                i_inc;
        logic                j_clr;
        logic                j_inc;
        logic                w_clr;
        logic                w_inc;
        logic                hold;
        logic                cmp;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                cnt_from_w;
        logic                cur_start;
        logic                cur_next;
        logic                cur_prev;
        logic                cur_del;
        logic                cur_keep;
        logic                cur_dd_fin;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_entry;
        logic                emit_last;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            full;
        logic            i_end;
        logic            i_last;
        logic            j_end;
        logic            id_match;
        logic            seen;
        logic            cur_valid;
        logic            cur_head;
        logic            out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: sv/circular_playlist_table.sv
// append writes at the tail unless full; start/next/previous move the cursor, then
// read and emit the entry under it; delete compares entries up to the match, then
// shifts every later entry down; dedup compares each entry with those already kept
// and keeps it if new; list emits each entry in turn; one request in flight, next
// accepted once the walk ends; reset clears count, cursor and output valid at once;
// the entry store is not cleared and only slots below the entry count are ever read
`default_nettype none
module circular_playlist_table
    import cpl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [ID_W-1:0]     song_id,
    input  wire logic [DUR_W-1:0]    song_duration,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          out_id,
    output logic [DUR_W-1:0]         out_duration,
    output logic                     last
);

    cmd_t cmd;
    sts_t sts;

    cpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .song_id       (song_id),
        .song_duration (song_duration),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_id        (out_id),
        .out_duration  (out_duration),
        .last          (last)
    );

endmodule
`default_nettype wire

// File: sv/cpl_ctrl.sv
// controller state machine sequencing each request over the entry store
`default_nettype none
module cpl_ctrl
    import cpl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_APPEND:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (sts.full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.wr_sel      = WR_APPEND;
                                cmd.cnt_inc     = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_DELETE, OP_DEDUP, OP_LIST:
                    begin
                        if (sts.count_zero)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                                cmd.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.i_clr = 1'b1;
                            cmd.w_clr = 1'b1;
                            priority if (sts.op == OP_DELETE)
                                state_next = S_DEL_RD;
                            else if (sts.op == OP_DEDUP)
                                state_next = S_DD_RD;
                            else
                                state_next = S_LIST_RD;
                        end
                    end
                    OP_START:
                    begin
                        if (sts.count_zero)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                                cmd.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.cur_start = 1'b1;
                            state_next    = S_PLAY_RD;
                        end
                    end
                    OP_NEXT, OP_PREV:
                    begin
                        if (!sts.cur_valid || sts.count_zero
                            || (sts.op == OP_PREV && sts.cur_head))
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_NO_CURRENT;
                                cmd.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.cur_next = (sts.op == OP_NEXT);
                            cmd.cur_prev = (sts.op == OP_PREV);
                            state_next   = S_PLAY_RD;
                        end
                    end
                    default:
                    begin
                        // unused op code: no result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PLAY_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = S_PLAY_OUT;
            end
            S_PLAY_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_entry  = 1'b1;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DEL_RD:
            begin
                if (sts.i_end)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_NOT_FOUND;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_I;
                    state_next = S_DEL_CMP;
                end
            end
            S_DEL_CMP:
            begin
                if (sts.id_match)
                begin
                    // cursor fix-up uses the match slot before the shift moves i
                    cmd.cur_del = 1'b1;
                    state_next  = S_SHIFT_RD;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_DEL_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.i_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.cnt_dec     = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_I1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_sel = WR_SHIFT;
                cmd.i_inc  = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_DD_RD:
            begin
                if (sts.i_end)
                begin
                    if (sts.out_free)
                    begin
                        cmd.cnt_from_w  = 1'b1;
                        cmd.cur_dd_fin  = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_I;
                    state_next = S_DD_HOLD;
                end
            end
            S_DD_HOLD:
            begin
                cmd.hold   = 1'b1;
                cmd.j_clr  = 1'b1;
                state_next = S_DD_JRD;
            end
            S_DD_JRD:
            begin
                if (sts.j_end)
                begin
                    state_next = S_DD_DEC;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_J;
                    state_next = S_DD_JCMP;
                end
            end
            S_DD_JCMP:
            begin
                cmd.cmp    = 1'b1;
                cmd.j_inc  = 1'b1;
                state_next = S_DD_JRD;
            end
            S_DD_DEC:
            begin
                if (!sts.seen)
                begin
                    cmd.wr_sel   = WR_KEEP;
                    cmd.cur_keep = 1'b1;
                    cmd.w_inc    = 1'b1;
                end
                cmd.i_inc  = 1'b1;
                state_next = S_DD_RD;
            end
            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_I;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_entry  = 1'b1;
                    cmd.emit_last   = sts.i_last;
                    cmd.i_inc       = 1'b1;
                    state_next      = sts.i_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/cpl_dp.sv
// datapath: entry store, count, cursor, walk indexes and output register
`default_nettype none
module cpl_dp
    import cpl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [ID_W-1:0]     song_id,
    input  wire logic [DUR_W-1:0]    song_duration,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          out_id,
    output logic [DUR_W-1:0]         out_duration,
    output logic                     last
);

    logic [ID_W-1:0]     mem_id  [CAPACITY];
    logic [DUR_W-1:0]    mem_dur [CAPACITY];

    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic [ID_W-1:0]     rd_id_reg;
    logic [DUR_W-1:0]    rd_dur_reg;
    logic [ID_W-1:0]     hold_id_reg;
    logic [DUR_W-1:0]    hold_dur_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    w_reg, w_next;
    logic                seen_reg, seen_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]    cur_pos_reg, cur_pos_next;
    logic                kept_reg, kept_next;
    logic [IDX_W-1:0]    new_pos_reg, new_pos_next;
    logic                out_valid_reg, out_valid_next;

    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [DUR_W-1:0]    out_dur_reg;
    logic                last_reg;

    logic [CNT_W-1:0]    i_plus1;
    logic [CNT_W-1:0]    pos_ext;
    logic [CNT_W-1:0]    pos_plus1;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ID_W-1:0]     wr_id;
    logic [DUR_W-1:0]    wr_dur;
    logic                out_free;

    assign i_plus1   = i_reg + 1'b1;
    assign pos_ext   = CNT_W'(cur_pos_reg);
    assign pos_plus1 = pos_ext + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_I:    rd_addr = i_reg[IDX_W-1:0];
            RD_I1:   rd_addr = i_plus1[IDX_W-1:0];
            RD_J:    rd_addr = j_reg[IDX_W-1:0];
            RD_CUR:  rd_addr = cur_pos_reg;
            default: rd_addr = cur_pos_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = i_reg[IDX_W-1:0];
        wr_id   = rd_id_reg;
        wr_dur  = rd_dur_reg;
        unique case (cmd.wr_sel)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_APPEND:
            begin
                wr_addr = count_reg[IDX_W-1:0];
                wr_id   = id_reg;
                wr_dur  = dur_reg;
            end
            WR_SHIFT:
            begin
                wr_addr = i_reg[IDX_W-1:0];
            end
            WR_KEEP:
            begin
                wr_addr = w_reg[IDX_W-1:0];
                wr_id   = hold_id_reg;
                wr_dur  = hold_dur_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_addr]  <= wr_id;
            mem_dur[wr_addr] <= wr_dur;
        end
        if (cmd.rd_en)
        begin
            rd_id_reg  <= mem_id[rd_addr];
            rd_dur_reg <= mem_dur[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            id_reg  <= song_id;
            dur_reg <= song_duration;
        end
        if (cmd.hold)
        begin
            hold_id_reg  <= rd_id_reg;
            hold_dur_reg <= rd_dur_reg;
        end
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            out_id_reg  <= cmd.emit_entry ? rd_id_reg : '0;
            out_dur_reg <= cmd.emit_entry ? rd_dur_reg : '0;
            last_reg    <= cmd.emit_last;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        seen_next      = seen_reg;
        cur_valid_next = cur_valid_reg;
        cur_pos_next   = cur_pos_reg;
        kept_next      = kept_reg;
        new_pos_next   = new_pos_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.emit)
            out_valid_next = 1'b1;

        priority if (cmd.cnt_inc)
            count_next = count_reg + 1'b1;
        else if (cmd.cnt_dec)
            count_next = count_reg - 1'b1;
        else if (cmd.cnt_from_w)
            count_next = w_reg;

        priority if (cmd.i_clr)
            i_next = '0;
        else if (cmd.i_inc)
            i_next = i_plus1;

        priority if (cmd.j_clr)
            j_next = '0;
        else if (cmd.j_inc)
            j_next = j_reg + 1'b1;

        priority if (cmd.w_clr)
        begin
            w_next    = '0;
            kept_next = 1'b0;
        end
        else if (cmd.w_inc)
            w_next = w_reg + 1'b1;

        priority if (cmd.j_clr)
            seen_next = 1'b0;
        else if (cmd.cmp && rd_id_reg == hold_id_reg)
            seen_next = 1'b1;

        priority if (cmd.cur_start)
        begin
            cur_valid_next = 1'b1;
            cur_pos_next   = '0;
        end
        else if (cmd.cur_next)
        begin
            // wrap from the tail back to the head
            cur_pos_next = (pos_plus1 >= count_reg) ? '0 : IDX_W'(pos_plus1);
        end
        else if (cmd.cur_prev)
        begin
            cur_pos_next = cur_pos_reg - 1'b1;
        end
        else if (cmd.cur_del)
        begin
            if (cur_valid_reg)
            begin
                priority if (pos_ext == i_reg)
                    cur_valid_next = 1'b0;
                else if (pos_ext > i_reg)
                    cur_pos_next = cur_pos_reg - 1'b1;
            end
        end
        else if (cmd.cur_keep)
        begin
            if (cur_valid_reg && pos_ext == i_reg)
            begin
                kept_next    = 1'b1;
                new_pos_next = IDX_W'(w_reg);
            end
        end
        else if (cmd.cur_dd_fin)
        begin
            if (cur_valid_reg)
            begin
                cur_valid_next = kept_reg;
                if (kept_reg)
                    cur_pos_next = new_pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            seen_reg      <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_pos_reg   <= '0;
            kept_reg      <= 1'b0;
            new_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            seen_reg      <= seen_next;
            cur_valid_reg <= cur_valid_next;
            cur_pos_reg   <= cur_pos_next;
            kept_reg      <= kept_next;
            new_pos_reg   <= new_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg >= CNT_W'(CAPACITY));
        sts.i_end      = (i_reg == count_reg);
        sts.i_last     = (i_plus1 == count_reg);
        sts.j_end      = (j_reg == w_reg);
        sts.id_match   = (rd_id_reg == id_reg);
        sts.seen       = seen_reg;
        sts.cur_valid  = cur_valid_reg;
        sts.cur_head   = (cur_pos_reg == '0);
        sts.out_free   = out_free;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_duration = out_dur_reg;
    assign last         = last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pos_ext < count_reg))
        else $error("valid cursor points past the tail");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over a pending result");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_APPEND) |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("append written into a full table");

    a_keep_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_KEEP) |-> (w_reg <= i_reg))
        else $error("dedup write overtakes its read index");
`endif

endmodule
`default_nettype wire
